FILE: design/dttfp_pkg.sv
// shared types and constants for the decimal text to fixed point parser
`timescale 1ns / 1ps

package dttfp_pkg;

    localparam int CHAR_W    = 8;
    localparam int UNITS_W   = 64;
    localparam int SCALE_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int DIGIT_W   = 4;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 80;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 8'd255;
    localparam logic [UNITS_W-1:0] MAG_LIMIT = 64'd922337203685477579;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_INVALID = 2'd1;
    localparam status_t ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              no_character;
        logic              is_last;
    } item_t;

    typedef struct packed {
        logic [UNITS_W-1:0] magnitude;
        logic               is_negative;
        logic [SCALE_W-1:0] fraction_digits;
        status_t            status;
    } raw_result_t;

endpackage

FILE: design/dttfp_in_stage.sv
// input register stage holding one character transfer
`timescale 1ns / 1ps

module dttfp_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dttfp_pkg::item_t      s_item,
    output logic                  item_valid,
    input  logic                  item_take,
    output dttfp_pkg::item_t      item
);
    import dttfp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: design/dttfp_accum.sv
// per-character parse state, digit accumulation and result forming
`timescale 1ns / 1ps

module dttfp_accum (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_take,
    input  dttfp_pkg::item_t       item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output dttfp_pkg::raw_result_t res
);
    import dttfp_pkg::*;

    logic [UNITS_W-1:0] magnitude_reg;
    logic [UNITS_W-1:0] magnitude_next;
    logic [SCALE_W-1:0] scale_count_reg;
    logic [SCALE_W-1:0] scale_count_next;
    logic               is_negative_reg;
    logic               is_negative_next;
    logic               at_first_char_reg;
    logic               at_first_char_next;
    logic               point_seen_reg;
    logic               point_seen_next;
    logic               digit_seen_reg;
    logic               digit_seen_next;
    status_t            error_code_reg;
    status_t            error_code_next;

    logic [UNITS_W-1:0] mag_cur;
    logic [SCALE_W-1:0] scale_cur;
    logic               neg_cur;
    logic               first_cur;
    logic               point_cur;
    logic               digit_cur;
    status_t            err_cur;
    logic [DIGIT_W-1:0] digit_val;
    logic [UNITS_W-1:0] mag_times_ten;
    logic               fire;
    status_t            status_out;

    assign fire      = item_valid && res_ready;
    assign item_take = fire;
    assign digit_val = DIGIT_W'(item.character - CHAR_ZERO);
    assign mag_times_ten = {magnitude_reg[UNITS_W-4:0], 3'b000}
                         + {magnitude_reg[UNITS_W-2:0], 1'b0}
                         + {{(UNITS_W-DIGIT_W){1'b0}}, digit_val};

    always_comb
    begin
        mag_cur   = magnitude_reg;
        scale_cur = scale_count_reg;
        neg_cur   = is_negative_reg;
        first_cur = at_first_char_reg;
        point_cur = point_seen_reg;
        digit_cur = digit_seen_reg;
        err_cur   = error_code_reg;
        if (!item.no_character)
        begin
            first_cur = 1'b0;
            if (error_code_reg == ST_OK)
            begin
                if (at_first_char_reg &&
                    (item.character == CHAR_PLUS || item.character == CHAR_MINUS))
                begin
                    neg_cur = (item.character == CHAR_MINUS);
                end
                else if (item.character == CHAR_POINT && !point_seen_reg)
                begin
                    point_cur = 1'b1;
                end
                else if (item.character < CHAR_ZERO || item.character > CHAR_NINE)
                begin
                    err_cur = ST_INVALID;
                end
                else
                begin
                    digit_cur = 1'b1;
                    if (magnitude_reg > MAG_LIMIT)
                    begin
                        err_cur = ST_RANGE;
                    end
                    else if (point_seen_reg && scale_count_reg == SCALE_MAX)
                    begin
                        err_cur = ST_RANGE;
                    end
                    else
                    begin
                        mag_cur = mag_times_ten;
                        if (point_seen_reg)
                        begin
                            scale_cur = scale_count_reg + SCALE_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        status_out = err_cur;
        if (err_cur == ST_OK && !digit_cur)
        begin
            status_out = ST_INVALID;
        end
    end

    assign res_valid           = fire && item.is_last;
    assign res.magnitude       = mag_cur;
    assign res.is_negative     = neg_cur;
    assign res.fraction_digits = scale_cur;
    assign res.status          = status_out;

    always_comb
    begin
        magnitude_next     = magnitude_reg;
        scale_count_next   = scale_count_reg;
        is_negative_next   = is_negative_reg;
        at_first_char_next = at_first_char_reg;
        point_seen_next    = point_seen_reg;
        digit_seen_next    = digit_seen_reg;
        error_code_next    = error_code_reg;
        if (fire)
        begin
            if (item.is_last)
            begin
                magnitude_next     = '0;
                scale_count_next   = '0;
                is_negative_next   = 1'b0;
                at_first_char_next = 1'b1;
                point_seen_next    = 1'b0;
                digit_seen_next    = 1'b0;
                error_code_next    = ST_OK;
            end
            else
            begin
                magnitude_next     = mag_cur;
                scale_count_next   = scale_cur;
                is_negative_next   = neg_cur;
                at_first_char_next = first_cur;
                point_seen_next    = point_cur;
                digit_seen_next    = digit_cur;
                error_code_next    = err_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnitude_reg     <= '0;
            scale_count_reg   <= '0;
            is_negative_reg   <= 1'b0;
            at_first_char_reg <= 1'b1;
            point_seen_reg    <= 1'b0;
            digit_seen_reg    <= 1'b0;
            error_code_reg    <= ST_OK;
        end
        else
        begin
            magnitude_reg     <= magnitude_next;
            scale_count_reg   <= scale_count_next;
            is_negative_reg   <= is_negative_next;
            at_first_char_reg <= at_first_char_next;
            point_seen_reg    <= point_seen_next;
            digit_seen_reg    <= digit_seen_next;
            error_code_reg    <= error_code_next;
        end
    end

endmodule

FILE: design/dttfp_out_stage.sv
// result register with sign application and zeroing of error results
`timescale 1ns / 1ps

module dttfp_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    output logic                                res_ready,
    input  dttfp_pkg::raw_result_t              res,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dttfp_pkg::OUT_DATA_W-1:0]    m_data
);
    import dttfp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    raw_result_t res_reg;
    logic [UNITS_W-1:0] units;
    logic [SCALE_W-1:0] frac;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_comb
    begin
        units = '0;
        frac  = '0;
        if (res_reg.status == ST_OK)
        begin
            units = res_reg.is_negative ? (~res_reg.magnitude + UNITS_W'(1))
                                        : res_reg.magnitude;
            frac  = res_reg.fraction_digits;
        end
    end

    assign m_data = {{(OUT_DATA_W-UNITS_W-SCALE_W-STATUS_W){1'b0}},
                     res_reg.status, frac, units};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: design/decimal_text_to_fixed_point_top.sv
// top level of the decimal text to fixed point parser
// usage:
//   s_axis carries one ascii character per transfer; tdata holds the code,
//   tuser set marks a transfer with no character (empty text), tlast ends
//   the text. m_axis carries one result per text, sent on the tlast transfer:
//   tdata holds signed units, fraction digit count and status
//   (0 ok, 1 invalid, 2 out of range); units and count are zero on error.
//   a character is registered in the input register, then parsed into the
//   state and, on its tlast, into the result register; a result is valid on
//   m_axis once the result register holds it. throughput is one character
//   per cycle while m_axis does not stall, set by the combinational
//   multiply-by-ten-and-add on the 64-bit accumulator. reset clears the parse
//   state and empties both register stages. when m_axis stalls with a result
//   held, the result register holds and the parser and the input register
//   stop with it, so no transfer is lost or repeated.
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dttfp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // character
    input  logic                               s_axis_tuser,  // no_character
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [dttfp_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // units, fraction_digits, status
);
    import dttfp_pkg::*;

    item_t       s_item;
    item_t       item;
    logic        item_valid;
    logic        item_take;
    raw_result_t res;
    logic        res_valid;
    logic        res_ready;

    assign s_item.character    = s_axis_tdata;
    assign s_item.no_character = s_axis_tuser;
    assign s_item.is_last      = s_axis_tlast;

    dttfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    dttfp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    dttfp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata)
    );

endmodule
